### design/nnds_pkg.sv
package nnds_pkg;

   // Configuration port geometry
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   // Field widths fixed by the register map and the stream formats
   localparam int DIM_REG_W = 13;
   localparam int OFS_W     = 12;
   localparam int FB_W      = 13;
   localparam int PIX_W     = 32;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DST_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_X   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Y   = 3'd5;

   // Register reset values
   localparam logic [DIM_REG_W-1:0] SRC_WIDTH_RST  = 13'd640;
   localparam logic [DIM_REG_W-1:0] SRC_HEIGHT_RST = 13'd480;
   localparam logic [DIM_REG_W-1:0] DST_WIDTH_RST  = 13'd640;
   localparam logic [DIM_REG_W-1:0] DST_HEIGHT_RST = 13'd480;
   localparam logic [OFS_W-1:0]     OFFSET_X_RST   = 12'd0;
   localparam logic [OFS_W-1:0]     OFFSET_Y_RST   = 12'd0;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_pixel;
      logic [FB_W-1:0]  fb_x;
      logic [FB_W-1:0]  fb_y;
      logic             frame_end;
   } rsp_payload_type;

endpackage

### design/nnds_chan_if.sv
interface nnds_chan_if #(
   parameter type payload_type = nnds_pkg::req_payload_type
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### design/nnds_clamp.sv
module nnds_clamp #(
   parameter int MAX_DIM = 4096
) (
   input  logic [nnds_pkg::DIM_REG_W-1:0] src_width,
   input  logic [nnds_pkg::DIM_REG_W-1:0] src_height,
   input  logic [nnds_pkg::DIM_REG_W-1:0] dst_width,
   input  logic [nnds_pkg::DIM_REG_W-1:0] dst_height,
   output logic [$clog2(MAX_DIM):0]       sw,
   output logic [$clog2(MAX_DIM):0]       sh,
   output logic [$clog2(MAX_DIM):0]       dw,
   output logic [$clog2(MAX_DIM):0]       dh
);
   localparam int CW = $clog2(MAX_DIM) + 1;

   // Force a size into 1..hi
   function automatic logic [CW-1:0] clamp_dim(input logic [nnds_pkg::DIM_REG_W-1:0] v,
                                               input int hi);
      logic [CW-1:0] r;
      if (v == '0) begin
         r = CW'(1);
      end else if (int'(v) > hi) begin
         r = CW'(hi);
      end else begin
         r = CW'(v);
      end
      return r;
   endfunction

   always_comb begin
      sw = clamp_dim(src_width, MAX_DIM);
      sh = clamp_dim(src_height, MAX_DIM);
      dw = clamp_dim(dst_width, int'(sw));
      dh = clamp_dim(dst_height, int'(sh));
   end
endmodule

### design/nnds_sel.sv
module nnds_sel #(
   parameter int MAX_DIM = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          frame_start,
   input  logic [$clog2(MAX_DIM):0]      sw,
   input  logic [$clog2(MAX_DIM):0]      sh,
   input  logic [$clog2(MAX_DIM):0]      dw,
   input  logic [$clog2(MAX_DIM):0]      dh,
   input  logic [nnds_pkg::OFS_W-1:0]    offset_x,
   input  logic [nnds_pkg::OFS_W-1:0]    offset_y,
   output logic                          emit,
   output logic [nnds_pkg::FB_W-1:0]     fb_x,
   output logic [nnds_pkg::FB_W-1:0]     fb_y,
   output logic                          frame_end
);
   localparam int CW   = $clog2(MAX_DIM) + 1;
   localparam int AW   = 2 * CW;
   localparam int FB_W = nnds_pkg::FB_W;

   logic [CW-1:0] src_col_ff, src_row_ff, out_col_ff, out_row_ff;
   logic [CW-1:0] src_col_in, src_row_in, out_col_in, out_row_in;
   logic [AW-1:0] col_tgt_ff, col_src_ff, row_tgt_ff, row_src_ff;
   logic [AW-1:0] col_tgt_in, col_src_in, row_tgt_in, row_src_in;
   logic          row_sel_ff, row_sel_in;

   // state as seen by this pixel, after an optional frame restart
   logic [CW-1:0] c_scol, c_srow, c_ocol, c_orow;
   logic [AW-1:0] c_ctgt, c_csrc, c_rtgt, c_rsrc;
   logic          c_rsel;
   logic [CW-1:0] scol_inc, srow_inc, orow_nxt;
   logic [AW-1:0] rtgt_nxt, rsrc_inc;

   always_comb begin
      if (frame_start) begin
         c_scol = '0; c_srow = '0; c_ocol = '0; c_orow = '0;
         c_ctgt = '0; c_csrc = '0; c_rtgt = '0; c_rsrc = '0;
         c_rsel = 1'b1;
      end else begin
         c_scol = src_col_ff; c_srow = src_row_ff;
         c_ocol = out_col_ff; c_orow = out_row_ff;
         c_ctgt = col_tgt_ff; c_csrc = col_src_ff;
         c_rtgt = row_tgt_ff; c_rsrc = row_src_ff;
         c_rsel = row_sel_ff;
      end

      emit = c_rsel && (c_orow < dh) && (c_ocol < dw) && (c_ctgt < c_csrc + AW'(dw));
      fb_x = FB_W'(c_ocol) + FB_W'(offset_x);
      fb_y = FB_W'(c_orow) + FB_W'(offset_y);
      frame_end = (c_ocol + CW'(1) == dw) && (c_orow + CW'(1) == dh);

      out_col_in = emit ? c_ocol + CW'(1) : c_ocol;
      col_tgt_in = emit ? c_ctgt + AW'(sw) : c_ctgt;
      scol_inc   = c_scol + CW'(1);
      src_col_in = scol_inc;
      col_src_in = c_csrc + AW'(dw);
      src_row_in = c_srow;
      out_row_in = c_orow;
      row_tgt_in = c_rtgt;
      row_src_in = c_rsrc;
      row_sel_in = c_rsel;

      // output row advances only if this source row fed one
      orow_nxt = c_orow;
      rtgt_nxt = c_rtgt;
      if (c_rsel && (c_orow < dh)) begin
         orow_nxt = c_orow + CW'(1);
         rtgt_nxt = c_rtgt + AW'(sh);
      end
      srow_inc = c_srow + CW'(1);
      rsrc_inc = c_rsrc + AW'(dh);

      if (scol_inc >= sw) begin
         src_col_in = '0;
         out_col_in = '0;
         col_tgt_in = '0;
         col_src_in = '0;
         if (srow_inc >= sh) begin
            src_row_in = '0;
            out_row_in = '0;
            row_tgt_in = '0;
            row_src_in = '0;
            row_sel_in = 1'b1;
         end else begin
            src_row_in = srow_inc;
            out_row_in = orow_nxt;
            row_tgt_in = rtgt_nxt;
            row_src_in = rsrc_inc;
            row_sel_in = (orow_nxt < dh) && (rtgt_nxt < rsrc_inc + AW'(dh));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff <= '0; src_row_ff <= '0; out_col_ff <= '0; out_row_ff <= '0;
         col_tgt_ff <= '0; col_src_ff <= '0; row_tgt_ff <= '0; row_src_ff <= '0;
         row_sel_ff <= 1'b1;
      end else if (step) begin
         src_col_ff <= src_col_in; src_row_ff <= src_row_in;
         out_col_ff <= out_col_in; out_row_ff <= out_row_in;
         col_tgt_ff <= col_tgt_in; col_src_ff <= col_src_in;
         row_tgt_ff <= row_tgt_in; row_src_ff <= row_src_in;
         row_sel_ff <= row_sel_in;
      end
   end
endmodule

### design/nearest_neighbor_downscale_place.sv
// Nearest-neighbor downscaler that places the scaled image in a framebuffer.
// req_chan carries source pixels in raster order; frame_start marks source
// position (0,0). rsp_chan carries each selected pixel with its framebuffer
// column and row (output position plus offset_x/offset_y, modulo 8192) and
// frame_end on the last output pixel of the frame. Source pixels that no
// output position maps to produce no transfer on rsp_chan.
// The req_chan transfer loads the input register, and the result register
// loads from it once the result register can advance; a stalled rsp_chan
// can hold a pixel in the input register in between.
// One pixel per clock while rsp_chan does not stall. Selection uses step
// accumulators, one add and compare per axis, and is combinational.
// The csr_ port writes size and offset registers; destination sizes are
// clamped to the source size, source sizes to 1..MAX_DIM. Write them only
// while no pixel is in flight.
// Reset (synchronous, active high) restores the default 640x480 geometry,
// zero offsets, and the start-of-frame counter state; both stages empty.
// When rsp_chan stalls, the result register holds and the input register
// keeps taking one more pixel; after that req_chan.ready drops.
module nearest_neighbor_downscale_place #(
   parameter int MAX_DIM    = 4096,
   parameter int PIXEL_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   nnds_chan_if.sink                         req_chan,
   nnds_chan_if.source                       rsp_chan,
   input  logic                              csr_write_en,
   input  logic [nnds_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [nnds_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   localparam int CW = $clog2(MAX_DIM) + 1;

   // configuration registers
   logic [nnds_pkg::DIM_REG_W-1:0] src_width_ff, src_height_ff;
   logic [nnds_pkg::DIM_REG_W-1:0] dst_width_ff, dst_height_ff;
   logic [nnds_pkg::OFS_W-1:0]     offset_x_ff, offset_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= nnds_pkg::SRC_WIDTH_RST;
         src_height_ff <= nnds_pkg::SRC_HEIGHT_RST;
         dst_width_ff  <= nnds_pkg::DST_WIDTH_RST;
         dst_height_ff <= nnds_pkg::DST_HEIGHT_RST;
         offset_x_ff   <= nnds_pkg::OFFSET_X_RST;
         offset_y_ff   <= nnds_pkg::OFFSET_Y_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            nnds_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata;
            nnds_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_wdata;
            nnds_pkg::CSR_DST_WIDTH:  dst_width_ff  <= csr_wdata;
            nnds_pkg::CSR_DST_HEIGHT: dst_height_ff <= csr_wdata;
            nnds_pkg::CSR_OFFSET_X:   offset_x_ff   <= csr_wdata[nnds_pkg::OFS_W-1:0];
            nnds_pkg::CSR_OFFSET_Y:   offset_y_ff   <= csr_wdata[nnds_pkg::OFS_W-1:0];
            default: ; // unmapped index: drop the write
         endcase
      end
   end

   // effective sizes after clamping
   logic [CW-1:0] sw, sh, dw, dh;

   nnds_clamp #(.MAX_DIM(MAX_DIM)) u_clamp (
      .src_width  (src_width_ff),
      .src_height (src_height_ff),
      .dst_width  (dst_width_ff),
      .dst_height (dst_height_ff),
      .sw         (sw),
      .sh         (sh),
      .dw         (dw),
      .dh         (dh)
   );

   // input register; the result register frees it when it can take a result
   logic                  s1_valid_ff, s1_valid_in;
   logic [PIXEL_BITS-1:0] s1_pixel_ff;
   logic                  s1_fs_ff;
   logic                  advance, step, req_xfer;

   logic                      out_valid_ff;
   nnds_pkg::rsp_payload_type out_payload_ff, out_payload_in;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign step           = s1_valid_ff && advance;
   assign req_chan.ready = advance || !s1_valid_ff;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_pixel_ff <= req_chan.payload.pixel[PIXEL_BITS-1:0];
         s1_fs_ff    <= req_chan.payload.frame_start;
      end
   end

   // selection and counter state
   logic                      emit, frame_end;
   logic [nnds_pkg::FB_W-1:0] fb_x, fb_y;

   nnds_sel #(.MAX_DIM(MAX_DIM)) u_sel (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .frame_start (s1_fs_ff),
      .sw          (sw),
      .sh          (sh),
      .dw          (dw),
      .dh          (dh),
      .offset_x    (offset_x_ff),
      .offset_y    (offset_y_ff),
      .emit        (emit),
      .fb_x        (fb_x),
      .fb_y        (fb_y),
      .frame_end   (frame_end)
   );

   // result register
   always_comb begin
      out_payload_in.out_pixel = nnds_pkg::PIX_W'(s1_pixel_ff);
      out_payload_in.fb_x      = fb_x;
      out_payload_in.fb_y      = fb_y;
      out_payload_in.frame_end = frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= step && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         out_payload_ff <= out_payload_in;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_payload_ff;
endmodule
